>>> hdl/grid_paths_bounded_jump_count_top_defines.svh
// Assertion macros for the grid path counter.
`ifndef GRID_PATHS_BOUNDED_JUMP_COUNT_TOP_DEFINES_SVH
`define GRID_PATHS_BOUNDED_JUMP_COUNT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define GPBJ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpbj assertion failed");
`define GPBJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpbj assertion failed");
`else
`define GPBJ_ASSERT_SAME(lbl, ante, cons)
`define GPBJ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/gpbj_pkg.sv
// Shared constants, types and controller states for the grid path counter.
package gpbj_pkg;

    localparam int MAX_SIDE  = 32;
    localparam int IDX_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W    = 6;
    localparam int JUMP_W    = 6;
    localparam int WAYS_W    = 64;
    localparam int SUM_W     = WAYS_W + IDX_W;
    localparam int EXT_W     = (IDX_W + 1 > SIDE_W) ? IDX_W + 1 : SIDE_W;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic             calc;
        logic             upd;
        logic             row_end;
        logic             load;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

>>> hdl/gpbj_ctrl.sv
// Controller: input handshake, side clamp and the row/column sweep over the grid.
module gpbj_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gpbj_pkg::SIDE_W-1:0]  s_side,
    output gpbj_pkg::cmd_t               cmd,
    input  gpbj_pkg::status_t            status
);

    gpbj_pkg::state_t                state_reg, state_next;
    logic [gpbj_pkg::IDX_W-1:0]      row_reg, row_next;
    logic [gpbj_pkg::IDX_W-1:0]      col_reg, col_next;
    logic [gpbj_pkg::IDX_W-1:0]      last_reg, last_next;
    logic [gpbj_pkg::EXT_W-1:0]      side_ext;
    logic [gpbj_pkg::EXT_W-1:0]      side_clamped;
    logic                            row_done;
    logic                            grid_done;

    always_comb begin
        side_ext = gpbj_pkg::EXT_W'(s_side);
        if (side_ext == '0) begin
            side_clamped = gpbj_pkg::EXT_W'(1);
        end else if (side_ext > gpbj_pkg::EXT_W'(gpbj_pkg::MAX_SIDE)) begin
            side_clamped = gpbj_pkg::EXT_W'(gpbj_pkg::MAX_SIDE);
        end else begin
            side_clamped = side_ext;
        end
    end

    assign row_done  = (col_reg == last_reg);
    assign grid_done = row_done && (row_reg == last_reg);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        last_next  = last_reg;
        case (state_reg)
            gpbj_pkg::ST_IDLE: begin
                if (s_valid) begin
                    last_next  = gpbj_pkg::IDX_W'(side_clamped - gpbj_pkg::EXT_W'(1));
                    row_next   = '0;
                    col_next   = '0;
                    state_next = gpbj_pkg::ST_CALC;
                end
            end
            gpbj_pkg::ST_CALC: begin
                state_next = gpbj_pkg::ST_UPD;
            end
            gpbj_pkg::ST_UPD: begin
                if (grid_done) begin
                    state_next = gpbj_pkg::ST_FIN;
                end else begin
                    state_next = gpbj_pkg::ST_CALC;
                    if (row_done) begin
                        col_next = '0;
                        row_next = row_reg + gpbj_pkg::IDX_W'(1);
                    end else begin
                        col_next = col_reg + gpbj_pkg::IDX_W'(1);
                    end
                end
            end
            gpbj_pkg::ST_FIN: begin
                if (!status.out_busy) begin
                    state_next = gpbj_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gpbj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.row     = row_reg;
        cmd.col     = col_reg;
        cmd.row_end = row_done;
        case (state_reg)
            gpbj_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            gpbj_pkg::ST_CALC: begin
                cmd.calc = 1'b1;
            end
            gpbj_pkg::ST_UPD: begin
                cmd.upd = 1'b1;
            end
            gpbj_pkg::ST_FIN: begin
                cmd.load = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpbj_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> hdl/gpbj_dp.sv
// Datapath: sliding window sums, cell store, saturation and the result register.
module gpbj_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [gpbj_pkg::JUMP_W-1:0]  s_max_jump,
    input  gpbj_pkg::cmd_t               cmd,
    output gpbj_pkg::status_t            status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gpbj_pkg::WAYS_W-1:0]  m_ways,
    output logic                         m_overflowed
);

    logic [gpbj_pkg::WAYS_W-1:0] mem [gpbj_pkg::MEM_DEPTH];

    logic [gpbj_pkg::JUMP_W-1:0] jump_reg;
    logic [gpbj_pkg::SUM_W-1:0]  row_sum_reg;
    logic [gpbj_pkg::SUM_W-1:0]  col_sum_reg [gpbj_pkg::MAX_SIDE];
    logic [gpbj_pkg::WAYS_W-1:0] cell_reg;
    logic [gpbj_pkg::WAYS_W-1:0] left_reg;
    logic [gpbj_pkg::WAYS_W-1:0] up_reg;
    logic                        left_ok_reg;
    logic                        up_ok_reg;
    logic                        ovf_reg;
    logic                        m_valid_reg;
    logic [gpbj_pkg::WAYS_W-1:0] ways_reg;
    logic                        overflowed_reg;

    logic                        first_cell;
    logic                        jump_nz;
    logic [gpbj_pkg::SUM_W:0]    total;
    logic                        sat;
    logic [gpbj_pkg::WAYS_W-1:0] cell_val;
    logic [gpbj_pkg::EXT_W-1:0]  row_ext;
    logic [gpbj_pkg::EXT_W-1:0]  col_ext;
    logic [gpbj_pkg::EXT_W-1:0]  jump_ext;
    logic [gpbj_pkg::EXT_W-1:0]  left_col;
    logic [gpbj_pkg::EXT_W-1:0]  up_row;
    logic [gpbj_pkg::ADDR_W-1:0] wr_addr;
    logic [gpbj_pkg::ADDR_W-1:0] left_addr;
    logic [gpbj_pkg::ADDR_W-1:0] up_addr;
    logic [gpbj_pkg::SUM_W-1:0]  row_sum_upd;
    logic [gpbj_pkg::SUM_W-1:0]  col_sum_upd;

    assign first_cell = (cmd.row == '0) && (cmd.col == '0);
    assign jump_nz    = (jump_reg != '0);
    assign total      = (gpbj_pkg::SUM_W + 1)'(row_sum_reg)
                      + (gpbj_pkg::SUM_W + 1)'(col_sum_reg[cmd.col]);
    assign sat        = |total[gpbj_pkg::SUM_W:gpbj_pkg::WAYS_W];

    always_comb begin
        if (first_cell) begin
            cell_val = gpbj_pkg::WAYS_W'(1);
        end else if (sat) begin
            cell_val = '1;
        end else begin
            cell_val = total[gpbj_pkg::WAYS_W-1:0];
        end
    end

    assign row_ext   = gpbj_pkg::EXT_W'(cmd.row);
    assign col_ext   = gpbj_pkg::EXT_W'(cmd.col);
    assign jump_ext  = gpbj_pkg::EXT_W'(jump_reg);
    assign left_col  = col_ext - jump_ext;
    assign up_row    = row_ext - jump_ext;
    assign wr_addr   = {cmd.row, cmd.col};
    assign left_addr = {cmd.row, left_col[gpbj_pkg::IDX_W-1:0]};
    assign up_addr   = {up_row[gpbj_pkg::IDX_W-1:0], cmd.col};

    assign row_sum_upd = row_sum_reg + gpbj_pkg::SUM_W'(cell_reg)
                       - (left_ok_reg ? gpbj_pkg::SUM_W'(left_reg) : '0);
    assign col_sum_upd = col_sum_reg[cmd.col] + gpbj_pkg::SUM_W'(cell_reg)
                       - (up_ok_reg ? gpbj_pkg::SUM_W'(up_reg) : '0);

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            mem[wr_addr] <= cell_val;
            left_reg     <= mem[left_addr];
            up_reg       <= mem[up_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            jump_reg    <= s_max_jump;
            row_sum_reg <= '0;
            for (int i = 0; i < gpbj_pkg::MAX_SIDE; i++) begin
                col_sum_reg[i] <= '0;
            end
        end
        if (cmd.calc) begin
            cell_reg    <= cell_val;
            left_ok_reg <= jump_nz && (col_ext >= jump_ext);
            up_ok_reg   <= jump_nz && (row_ext >= jump_ext);
        end
        if (cmd.upd) begin
            if (cmd.row_end) begin
                row_sum_reg <= '0;
            end else if (jump_nz) begin
                row_sum_reg <= row_sum_upd;
            end
            if (jump_nz) begin
                col_sum_reg[cmd.col] <= col_sum_upd;
            end
        end
        if (cmd.load) begin
            ways_reg       <= cell_reg;
            overflowed_reg <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                ovf_reg <= 1'b0;
            end else if (cmd.calc && !first_cell && sat) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_ways          = ways_reg;
    assign m_overflowed    = overflowed_reg;

endmodule

>>> hdl/grid_paths_bounded_jump_count_top.sv
// Grid path counter with bounded jumps: controller, datapath and checks.
//
// Input channel s_: one word carries s_side (grid side, clamped to 1..32) and
// s_max_jump (longest move). Result channel m_: one word per input with m_ways,
// the saturated path count to the far corner, and m_overflowed.
// Both channels use valid/ready; a word moves when both are high.
// The grid is swept row by row; each cell passes through CALC, which forms the
// saturated window sum and writes the cell store, then UPD, which slides the
// row and column window sums using the two cells read back from the store.
// The next item can be accepted from the cycle after the result is loaded;
// no new item is taken while one is still being swept. The CALC/UPD cell loop
// on the single-write, dual-read cell store sets the rate at which items run.
// The result sits in an output register: a stalled receiver holds m_ valid and
// its payload while the next item is accepted and computed; only the final
// load waits for the register to empty.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// m_valid; the cell store needs no clearing, each item writes a cell before it
// reads it.
`include "grid_paths_bounded_jump_count_top_defines.svh"

module grid_paths_bounded_jump_count_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gpbj_pkg::SIDE_W-1:0]  s_side,
    input  logic [gpbj_pkg::JUMP_W-1:0]  s_max_jump,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gpbj_pkg::WAYS_W-1:0]  m_ways,
    output logic                         m_overflowed
);

    gpbj_pkg::cmd_t    cmd;
    gpbj_pkg::status_t status;

    gpbj_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_side  (s_side),
        .cmd     (cmd),
        .status  (status)
    );

    gpbj_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_max_jump   (s_max_jump),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ways       (m_ways),
        .m_overflowed (m_overflowed)
    );

    `GPBJ_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `GPBJ_ASSERT_SAME(a_load_into_free_reg, cmd.load, !(m_valid && !m_ready))
    `GPBJ_ASSERT_NEXT(a_calc_then_update, cmd.calc, cmd.upd)
    `GPBJ_ASSERT_SAME(a_one_command, 1'b1, $onehot0({cmd.start, cmd.calc, cmd.upd, cmd.load}))

endmodule
